// ----- hdl/graph_bridge_finder_defines.svh -----
// ----------------------------------------------------------------------------
// graph_bridge_finder_defines
// Assertion macros for the bridge finder.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BRIDGE_FINDER_DEFINES_SVH
`define GRAPH_BRIDGE_FINDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GBF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define GBF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define GBF_ASSERT(lbl, prop, msg)
`define GBF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/gbf_pkg.sv -----
// ----------------------------------------------------------------------------
// gbf_pkg
// Types, sizes and codes shared by the bridge finder.
// ----------------------------------------------------------------------------
package gbf_pkg;
   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 4096;
   localparam int SLOTS     = 2 * MAX_EDGES + 2;
   localparam int NODE_W    = 11;
   localparam int VIDX_W    = $clog2(MAX_NODES);
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int MARK_W    = $clog2(MAX_EDGES);
   localparam int LIST_W    = 2 * NODE_W;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_RUN   = 2'd1;
   localparam logic [1:0] KIND_FETCH = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_VERTEX = 2'd2;
   localparam logic [1:0] STAT_INDEX  = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NODE_W-1:0] end_a;
      logic [NODE_W-1:0] end_b;
      logic [9:0]        bridge_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [9:0]        bridge_count;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0] vertex;
      logic [SLOT_W-1:0] enter;
      logic [SLOT_W-1:0] iter;
      logic [NODE_W-1:0] disc;
      logic [NODE_W-1:0] low;
   } stk_type;

   function automatic logic [VIDX_W-1:0] vidx(input logic [NODE_W-1:0] v);
      logic [NODE_W-1:0] t;
      t = v - NODE_W'(1);
      return t[VIDX_W-1:0];
   endfunction

   function automatic logic [MARK_W-1:0] kidx(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] h;
      h = {1'b0, s[SLOT_W-1:1]} - SLOT_W'(1);
      return h[MARK_W-1:0];
   endfunction
endpackage

// ----- hdl/graph_bridge_finder.sv -----
// ----------------------------------------------------------------------------
// graph_bridge_finder: Tarjan bridge search over an adjacency-list RAM.
// Add writes both slots of an edge (a bad vertex or full store is answered without
// writing). Fetch reads the bridge list; Clear sweeps the head RAM; Run clears, walks
// the graph and lists the bridges. One transaction at a time.
// Sync reset, then a sweep that clears every head entry with busy high; rsp never stalls.
// ----------------------------------------------------------------------------
module graph_bridge_finder (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gbf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gbf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [10:0]      csr_wdata
);
`include "graph_bridge_finder_defines.svh"

   typedef enum logic [14:0] {
      S_IDLE   = 15'h0001,
      S_INIT   = 15'h0002,
      S_ADD1   = 15'h0004,
      S_ADD2   = 15'h0008,
      S_FETCH  = 15'h0010,
      S_RCLR   = 15'h0020,
      S_RROOT  = 15'h0040,
      S_RROOTW = 15'h0080,
      S_STEP   = 15'h0100,
      S_EDGE   = 15'h0200,
      S_EDGEW  = 15'h0400,
      S_POPW   = 15'h0800,
      S_LIST   = 15'h1000,
      S_LISTA  = 15'h2000,
      S_LISTB  = 15'h4000
   } state_type;

   localparam int NW = gbf_pkg::NODE_W;
   localparam int VW = gbf_pkg::VIDX_W;
   localparam int SW = gbf_pkg::SLOT_W;
   localparam int MW = gbf_pkg::MARK_W;
   localparam int LW = gbf_pkg::LIST_W;
   localparam int TW = $bits(gbf_pkg::stk_type);

   state_type         state_ff, state_in;
   logic [NW-1:0]     ncnt_ff, ncnt_in, n_live;
   gbf_pkg::req_type  req_ff, req_in;
   gbf_pkg::rsp_type  rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;
   logic [MW-1:0]     clr_ff, clr_in;
   logic              rpend_ff, rpend_in;
   logic [NW-1:0]     r_ff, r_in;
   logic [NW-1:0]     sp_ff, sp_in;
   gbf_pkg::stk_type  top_ff, top_in;
   logic [SW-1:0]     e_ff, e_in;
   logic [NW-1:0]     u_ff, u_in;
   logic [NW-1:0]     time_ff, time_in, t_next;
   logic [NW-1:0]     found_ff, found_in;
   logic [SW-1:0]     fill_ff, fill_in;
   logic [SW-1:0]     s_ff, s_in;
   logic [NW-1:0]     bt_ff, bt_in;
   logic              mk_ff, mk_in;

   logic              head_we;
   logic [VW-1:0]     head_wa, head_ra;
   logic [SW-1:0]     head_wd, head_q;
   logic              tgt_we;
   logic [SW-1:0]     tgt_wa, tgt_ra;
   logic [NW-1:0]     tgt_wd, tgt_q;
   logic              lnk_we;
   logic [SW-1:0]     lnk_wa, lnk_ra;
   logic [SW-1:0]     lnk_wd, lnk_q;
   logic              disc_we;
   logic [VW-1:0]     disc_wa, disc_ra;
   logic [NW-1:0]     disc_wd, disc_q;
   logic              mark_we;
   logic [MW-1:0]     mark_wa, mark_ra;
   logic              mark_wd, mark_q;
   logic              stk_we;
   logic [VW-1:0]     stk_wa, stk_ra;
   logic [TW-1:0]     stk_wd, stk_q;
   gbf_pkg::stk_type  pop_q;
   logic              lst_we;
   logic [VW-1:0]     lst_wa, lst_ra;
   logic [LW-1:0]     lst_wd, lst_q;

   gbf_ram #(.WIDTH(SW), .DEPTH(gbf_pkg::MAX_NODES)) u_head (
      .clock(clock), .we(head_we), .waddr(head_wa), .wdata(head_wd),
      .raddr(head_ra), .rdata(head_q));
   gbf_ram #(.WIDTH(NW), .DEPTH(gbf_pkg::SLOTS)) u_tgt (
      .clock(clock), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
      .raddr(tgt_ra), .rdata(tgt_q));
   gbf_ram #(.WIDTH(SW), .DEPTH(gbf_pkg::SLOTS)) u_lnk (
      .clock(clock), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
      .raddr(lnk_ra), .rdata(lnk_q));
   gbf_ram #(.WIDTH(NW), .DEPTH(gbf_pkg::MAX_NODES)) u_disc (
      .clock(clock), .we(disc_we), .waddr(disc_wa), .wdata(disc_wd),
      .raddr(disc_ra), .rdata(disc_q));
   gbf_ram #(.WIDTH(1), .DEPTH(gbf_pkg::MAX_EDGES)) u_mark (
      .clock(clock), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
      .raddr(mark_ra), .rdata(mark_q));
   gbf_ram #(.WIDTH(TW), .DEPTH(gbf_pkg::MAX_NODES)) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_q));
   gbf_ram #(.WIDTH(LW), .DEPTH(gbf_pkg::MAX_NODES)) u_lst (
      .clock(clock), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd),
      .raddr(lst_ra), .rdata(lst_q));

   assign pop_q      = gbf_pkg::stk_type'(stk_q);
   assign t_next     = time_ff + NW'(1);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      if (ncnt_ff == '0) begin
         n_live = NW'(1);
      end else if (ncnt_ff > NW'(gbf_pkg::MAX_NODES)) begin
         n_live = NW'(gbf_pkg::MAX_NODES);
      end else begin
         n_live = ncnt_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ncnt_in   = csr_we ? csr_wdata : ncnt_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      clr_in    = clr_ff;
      rpend_in  = rpend_ff;
      r_in      = r_ff;
      sp_in     = sp_ff;
      top_in    = top_ff;
      e_in      = e_ff;
      u_in      = u_ff;
      time_in   = time_ff;
      found_in  = found_ff;
      fill_in   = fill_ff;
      s_in      = s_ff;
      bt_in     = bt_ff;
      mk_in     = mk_ff;

      head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = gbf_pkg::vidx(req_data.end_a);
      tgt_we  = 1'b0; tgt_wa  = '0; tgt_wd  = '0; tgt_ra  = '0;
      lnk_we  = 1'b0; lnk_wa  = '0; lnk_wd  = '0; lnk_ra  = '0;
      disc_we = 1'b0; disc_wa = '0; disc_wd = '0; disc_ra = '0;
      mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0; mark_ra = '0;
      stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
      lst_we  = 1'b0; lst_wa  = '0; lst_wd  = '0; lst_ra  = req_data.bridge_index;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.kind)
                  gbf_pkg::KIND_ADD: begin
                     if (req_data.end_a == '0 || req_data.end_b == '0 ||
                         req_data.end_a > n_live || req_data.end_b > n_live) begin
                        rsp_in    = '{gbf_pkg::STAT_VERTEX, found_ff[9:0], '0, '0};
                        strobe_in = 1'b1;
                     end else if (({1'b0, fill_ff} + (SW+1)'(2)) >
                                  (SW+1)'(2 * gbf_pkg::MAX_EDGES + 1)) begin
                        rsp_in    = '{gbf_pkg::STAT_FULL, found_ff[9:0], '0, '0};
                        strobe_in = 1'b1;
                     end else begin
                        state_in = S_ADD1;
                     end
                  end
                  gbf_pkg::KIND_RUN: begin
                     clr_in   = '0;
                     found_in = '0;
                     time_in  = '0;
                     state_in = S_RCLR;
                  end
                  gbf_pkg::KIND_FETCH: begin
                     state_in = S_FETCH;
                  end
                  gbf_pkg::KIND_CLEAR: begin
                     clr_in   = '0;
                     rpend_in = 1'b1;
                     fill_in  = SW'(1);
                     time_in  = '0;
                     found_in = '0;
                     state_in = S_INIT;
                  end
                  default: ;
               endcase
            end
         end
         S_ADD1: begin
            tgt_we  = 1'b1; tgt_wa = fill_ff + SW'(1); tgt_wd = req_ff.end_b;
            lnk_we  = 1'b1; lnk_wa = fill_ff + SW'(1); lnk_wd = head_q;
            head_we = 1'b1; head_wa = gbf_pkg::vidx(req_ff.end_a);
            head_wd = fill_ff + SW'(1);
            head_ra = gbf_pkg::vidx(req_ff.end_b);
            state_in = S_ADD2;
         end
         S_ADD2: begin
            tgt_we  = 1'b1; tgt_wa = fill_ff + SW'(2); tgt_wd = req_ff.end_a;
            lnk_we  = 1'b1; lnk_wa = fill_ff + SW'(2);
            // self-loop: head was just rewritten by the first slot
            lnk_wd  = (req_ff.end_a == req_ff.end_b) ? fill_ff + SW'(1) : head_q;
            head_we = 1'b1; head_wa = gbf_pkg::vidx(req_ff.end_b);
            head_wd = fill_ff + SW'(2);
            fill_in   = fill_ff + SW'(2);
            rsp_in    = '{gbf_pkg::STAT_OK, found_ff[9:0], '0, '0};
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_FETCH: begin
            if ({1'b0, req_ff.bridge_index} >= found_ff) begin
               rsp_in = '{gbf_pkg::STAT_INDEX, found_ff[9:0], '0, '0};
            end else begin
               rsp_in = '{gbf_pkg::STAT_OK, found_ff[9:0], lst_q[LW-1:NW], lst_q[NW-1:0]};
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_INIT: begin
            head_we = 1'b1; head_wa = clr_ff[VW-1:0]; head_wd = '0;
            clr_in  = clr_ff + MW'(1);
            if (clr_ff[VW-1:0] == VW'(gbf_pkg::MAX_NODES - 1)) begin
               state_in = S_IDLE;
               if (rpend_ff) begin
                  rpend_in  = 1'b0;
                  rsp_in    = '{gbf_pkg::STAT_OK, '0, '0, '0};
                  strobe_in = 1'b1;
               end
            end
         end
         S_RCLR: begin
            disc_we = 1'b1; disc_wa = clr_ff[VW-1:0]; disc_wd = '0;
            mark_we = 1'b1; mark_wa = clr_ff; mark_wd = 1'b0;
            clr_in  = clr_ff + MW'(1);
            if (clr_ff == MW'(gbf_pkg::MAX_EDGES - 1)) begin
               r_in     = NW'(1);
               state_in = S_RROOT;
            end
         end
         S_RROOT: begin
            if (r_ff > n_live) begin
               s_in     = SW'(2);
               state_in = S_LIST;
            end else begin
               disc_ra  = gbf_pkg::vidx(r_ff);
               head_ra  = gbf_pkg::vidx(r_ff);
               state_in = S_RROOTW;
            end
         end
         S_RROOTW: begin
            r_in = r_ff + NW'(1);
            if (disc_q == '0) begin
               time_in = t_next;
               disc_we = 1'b1; disc_wa = gbf_pkg::vidx(r_ff); disc_wd = t_next;
               top_in  = '{r_ff, '0, head_q, t_next, t_next};
               sp_in   = NW'(1);
               state_in = S_STEP;
            end else begin
               state_in = S_RROOT;
            end
         end
         S_STEP: begin
            if (top_ff.iter == '0) begin
               if (sp_ff == NW'(1)) begin
                  sp_in    = '0;
                  state_in = S_RROOT;
               end else begin
                  stk_ra   = VW'(sp_ff - NW'(2));
                  state_in = S_POPW;
               end
            end else begin
               e_in     = top_ff.iter;
               tgt_ra   = top_ff.iter;
               lnk_ra   = top_ff.iter;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            top_in.iter = lnk_q;
            u_in        = tgt_q;
            disc_ra     = gbf_pkg::vidx(tgt_q);
            head_ra     = gbf_pkg::vidx(tgt_q);
            state_in    = S_EDGEW;
         end
         S_EDGEW: begin
            if (disc_q == '0) begin
               if (sp_ff != NW'(gbf_pkg::MAX_NODES)) begin
                  stk_we  = 1'b1; stk_wa = VW'(sp_ff - NW'(1)); stk_wd = top_ff;
                  time_in = t_next;
                  disc_we = 1'b1; disc_wa = gbf_pkg::vidx(u_ff); disc_wd = t_next;
                  top_in  = '{u_ff, e_ff, head_q, t_next, t_next};
                  sp_in   = sp_ff + NW'(1);
               end
            end else if (e_ff != (top_ff.enter ^ SW'(1))) begin
               if (disc_q < top_ff.low) begin
                  top_in.low = disc_q;
               end
            end
            state_in = S_STEP;
         end
         S_POPW: begin
            top_in = pop_q;
            if (top_ff.low < pop_q.low) begin
               top_in.low = top_ff.low;
            end
            if (top_ff.low > pop_q.disc) begin
               mark_we = 1'b1; mark_wa = gbf_pkg::kidx(top_ff.enter); mark_wd = 1'b1;
            end
            sp_in    = sp_ff - NW'(1);
            state_in = S_STEP;
         end
         S_LIST: begin
            if (s_ff >= fill_ff) begin
               rsp_in    = '{gbf_pkg::STAT_OK, found_ff[9:0], '0, '0};
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               mark_ra  = gbf_pkg::kidx(s_ff);
               tgt_ra   = s_ff;
               state_in = S_LISTA;
            end
         end
         S_LISTA: begin
            bt_in    = tgt_q;
            mk_in    = mark_q;
            tgt_ra   = s_ff + SW'(1);
            state_in = S_LISTB;
         end
         S_LISTB: begin
            if (mk_ff && found_ff != NW'(gbf_pkg::MAX_NODES)) begin
               lst_we   = 1'b1; lst_wa = found_ff[VW-1:0]; lst_wd = {tgt_q, bt_ff};
               found_in = found_ff + NW'(1);
            end
            s_in     = s_ff + SW'(2);
            state_in = S_LIST;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         ncnt_ff   <= NW'(gbf_pkg::MAX_NODES);
         strobe_ff <= 1'b0;
         clr_ff    <= '0;
         rpend_ff  <= 1'b0;
         r_ff      <= '0;
         sp_ff     <= '0;
         time_ff   <= '0;
         found_ff  <= '0;
         fill_ff   <= SW'(1);
         s_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         ncnt_ff   <= ncnt_in;
         strobe_ff <= strobe_in;
         clr_ff    <= clr_in;
         rpend_ff  <= rpend_in;
         r_ff      <= r_in;
         sp_ff     <= sp_in;
         time_ff   <= time_in;
         found_ff  <= found_in;
         fill_ff   <= fill_in;
         s_ff      <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      top_ff <= top_in;
      e_ff   <= e_in;
      u_ff   <= u_in;
      bt_ff  <= bt_in;
      mk_ff  <= mk_in;
   end

   `GBF_ASSERT(a_strobe_idle, rsp_strobe |-> !busy, "response strobe while busy")
   `GBF_ASSERT(a_run_busy, (start && !busy && req_data.kind == gbf_pkg::KIND_RUN) |=> busy, "run not taken")
   `GBF_ASSERT(a_sp_bound, sp_ff <= NW'(gbf_pkg::MAX_NODES), "walk stack overflow")
   `GBF_ASSERT(a_fill_odd, fill_ff[0], "edge fill lost pairing")
   `GBF_ASSERT_ALWAYS(a_reset_init, reset |=> (state_ff == S_INIT && !rsp_strobe), "reset sweep")
endmodule

// ----- hdl/gbf_ram.sv -----
// ----------------------------------------------------------------------------
// gbf_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- sim/graph_bridge_finder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_bridge_finder_tb
// Drives edge loads, bridge searches, fetches and clears into the bridge
// finder and checks every response against an in-bench low-link predictor.
// ----------------------------------------------------------------------------
module graph_bridge_finder_tb;

   localparam int TSLOTS = 2 * gbf_pkg::MAX_EDGES + 2;
   localparam int MAXN   = gbf_pkg::MAX_NODES;
   localparam int MAXE   = gbf_pkg::MAX_EDGES;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   gbf_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   gbf_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [10:0]      csr_wdata = '0;

   graph_bridge_finder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // graph shadow
   int unsigned nodes_cfg;
   int unsigned head_of[MAXN+1];
   int unsigned tgt_of[TSLOTS];
   int unsigned link_of[TSLOTS];
   int unsigned fill;
   int unsigned disc_of[MAXN+1];
   int unsigned low_of[MAXN+1];
   bit          is_bridge[MAXE];
   int unsigned sv_vtx[MAXN];
   int unsigned sv_in[MAXN];
   int unsigned sv_it[MAXN];
   int unsigned tick;
   int unsigned found_list[MAXN];
   int unsigned nfound;

   gbf_pkg::req_type pending_q[$];
   gbf_pkg::rsp_type expected_q[$];
   int          errors = 0;
   int          sent = 0;
   int          got = 0;
   int          gap_pct = 0;
   bit          hold_off = 1'b0;
   logic        taken = 1'b0;

   function automatic int unsigned live_n();
      if (nodes_cfg == 0) return 1;
      if (nodes_cfg > MAXN) return MAXN;
      return nodes_cfg;
   endfunction

   function automatic void wipe_graph();
      for (int i = 0; i <= MAXN; i++) begin
         head_of[i] = 0;
         disc_of[i] = 0;
      end
      for (int i = 0; i < MAXE; i++) is_bridge[i] = 0;
      fill = 1;
      tick = 0;
      nfound = 0;
   endfunction

   function automatic int unsigned mark_visit(int unsigned v);
      tick++;
      disc_of[v] = tick;
      low_of[v] = tick;
      return head_of[v];
   endfunction

   function automatic void find_bridges();
      int unsigned n, sp, v, e, p, u, k;
      n = live_n();
      for (int i = 0; i <= MAXN; i++) disc_of[i] = 0;
      for (int i = 0; i < MAXE; i++) is_bridge[i] = 0;
      tick = 0;
      nfound = 0;
      for (int unsigned r = 1; r <= n; r++) begin
         if (disc_of[r] != 0) continue;
         sv_vtx[0] = r;
         sv_in[0] = 0;
         sv_it[0] = mark_visit(r);
         sp = 1;
         while (sp > 0) begin
            v = sv_vtx[sp-1];
            e = sv_it[sp-1];
            if (e == 0) begin
               sp--;
               if (sp > 0) begin
                  p = sv_vtx[sp-1];
                  if (low_of[v] < low_of[p]) low_of[p] = low_of[v];
                  if (low_of[v] > disc_of[p]) begin
                     k = (sv_in[sp] >> 1) - 1;
                     if (k < MAXE) is_bridge[k] = 1;
                  end
               end
            end else if (e >= TSLOTS) begin
               sv_it[sp-1] = 0;
            end else begin
               sv_it[sp-1] = link_of[e];
               u = tgt_of[e];
               if (u > MAXN) continue;
               if (disc_of[u] == 0) begin
                  if (sp >= MAXN) continue;
                  sv_vtx[sp] = u;
                  sv_in[sp] = e;
                  sv_it[sp] = mark_visit(u);
                  sp++;
               end else if (e != (sv_in[sp-1] ^ 1)) begin
                  if (disc_of[u] < low_of[v]) low_of[v] = disc_of[u];
               end
            end
         end
      end
      for (int unsigned s = 2; s + 1 <= fill; s += 2) begin
         k = (s >> 1) - 1;
         if (k < MAXE && is_bridge[k] && nfound < MAXN) begin
            found_list[nfound] = ((tgt_of[s+1] & 'h7FF) << 11) | (tgt_of[s] & 'h7FF);
            nfound++;
         end
      end
   endfunction

   function automatic void link_slot(int unsigned f, int unsigned t);
      fill++;
      tgt_of[fill] = t;
      link_of[fill] = head_of[f];
      head_of[f] = fill;
   endfunction

   function automatic gbf_pkg::rsp_type predict_rsp(gbf_pkg::req_type rq);
      gbf_pkg::rsp_type r;
      int unsigned      n;
      n = live_n();
      r = '0;
      case (rq.kind)
         gbf_pkg::KIND_ADD: begin
            if (rq.end_a == 0 || rq.end_b == 0 || rq.end_a > n || rq.end_b > n)
               r.status = gbf_pkg::STAT_VERTEX;
            else if (fill + 2 > 2 * MAXE + 1)
               r.status = gbf_pkg::STAT_FULL;
            else begin
               link_slot(rq.end_a, rq.end_b);
               link_slot(rq.end_b, rq.end_a);
            end
         end
         gbf_pkg::KIND_RUN: find_bridges();
         gbf_pkg::KIND_FETCH: begin
            if (rq.bridge_index >= nfound) r.status = gbf_pkg::STAT_INDEX;
            else begin
               r.from_node = 11'((found_list[rq.bridge_index] >> 11) & 'h7FF);
               r.to_node = 11'(found_list[rq.bridge_index] & 'h7FF);
            end
         end
         default: wipe_graph();
      endcase
      r.bridge_count = nfound[9:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_q.push_back(predict_rsp(req_data));
         sent++;
      end
      taken <= !reset && start && !busy;
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (taken) begin
         // accepted at the last rising edge
         void'(pending_q.pop_front());
         if (pending_q.size() > 0 && !hold_off && $urandom_range(99) >= gap_pct) begin
            req_data <= pending_q[0];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_q.size() > 0 && !hold_off &&
                   $urandom_range(99) >= gap_pct) begin
         req_data <= pending_q[0];
         start <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      gbf_pkg::rsp_type ex;
      if (!reset && rsp_strobe) begin
         got++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %h", $time, rsp_data);
         end else begin
            ex = expected_q.pop_front();
            if (rsp_data.status !== ex.status) begin
               errors++;
               $display("%0t: status exp %0d got %0d", $time, ex.status, rsp_data.status);
            end
            if (rsp_data.bridge_count !== ex.bridge_count) begin
               errors++;
               $display("%0t: bridge_count exp %0d got %0d", $time, ex.bridge_count,
                        rsp_data.bridge_count);
            end
            if (rsp_data.from_node !== ex.from_node) begin
               errors++;
               $display("%0t: from_node exp %0d got %0d", $time, ex.from_node,
                        rsp_data.from_node);
            end
            if (rsp_data.to_node !== ex.to_node) begin
               errors++;
               $display("%0t: to_node exp %0d got %0d", $time, ex.to_node, rsp_data.to_node);
            end
         end
      end
   end

   function automatic gbf_pkg::req_type mk(logic [1:0] k, int unsigned a, int unsigned b,
                                           int unsigned ix);
      gbf_pkg::req_type r;
      r.kind = k;
      r.end_a = a[10:0];
      r.end_b = b[10:0];
      r.bridge_index = ix[9:0];
      return r;
   endfunction

   task automatic drain();
      while (pending_q.size() > 0 || expected_q.size() > 0 || start) @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_nodes(int unsigned v);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v[10:0];
      @(negedge clock);
      csr_we <= 1'b0;
      nodes_cfg = v & 'h7FF;
   endtask

   // one small random graph: edges, a run, fetches, some noise
   task automatic random_graph(int unsigned n);
      int unsigned ne, nf;
      ne = $urandom_range(1, (2 * n + 2 > 40) ? 40 : 2 * n + 2);
      for (int i = 0; i < ne; i++) begin
         if ($urandom_range(9) == 0)
            pending_q.push_back(mk(gbf_pkg::KIND_ADD, $urandom_range(2047), $urandom, 0));
         else
            pending_q.push_back(mk(gbf_pkg::KIND_ADD, $urandom_range(1, n),
                                   $urandom_range(1, n), 0));
      end
      pending_q.push_back(mk(gbf_pkg::KIND_RUN, $urandom, $urandom, $urandom));
      nf = $urandom_range(1, 6);
      for (int i = 0; i < nf; i++)
         pending_q.push_back(mk(gbf_pkg::KIND_FETCH, $urandom, $urandom,
                                ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, n)));
      if ($urandom_range(3) == 0) pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1, n, 0));
      if ($urandom_range(5) == 0) pending_q.push_back(mk(gbf_pkg::KIND_RUN, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_CLEAR, $urandom, $urandom, $urandom));
   endtask

   initial begin
      int unsigned n;
      nodes_cfg = 1024;
      wipe_graph();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: path 1-2-3 plus a cycle 3-4-5, self-loop, parallel pair
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 0, 1, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1, 1025, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 2047, 2047, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1, 2, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 2, 3, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 3, 4, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 4, 5, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 5, 3, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 6, 6, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 7, 8, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 8, 7, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1024, 1023, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_RUN, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 1));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 2));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 1023));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 9, 10, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 1));
      pending_q.push_back(mk(gbf_pkg::KIND_RUN, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_CLEAR, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 0));

      // node count lowered after loading
      write_nodes(3);
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1, 2, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 3, 4, 0));
      write_nodes(0);
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1, 1, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1, 2, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_RUN, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 0));
      write_nodes(2047);
      pending_q.push_back(mk(gbf_pkg::KIND_ADD, 1024, 1, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_RUN, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_FETCH, 0, 0, 0));
      pending_q.push_back(mk(gbf_pkg::KIND_CLEAR, 0, 0, 0));
      drain();

      // random phases with varying sender gaps
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = (ph == 0) ? 0 : (ph == 1) ? 51 : (ph == 2) ? 0 : 26;
         for (int g = 0; g < 30; g++) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 12);
            if (g % 10 == 0) write_nodes(($urandom_range(3) == 0) ? $urandom_range(2047) : n);
            random_graph(live_n());
            if (g == 15) begin
               hold_off = 1'b1;
               while (expected_q.size() > 0 || start) @(posedge clock);
               hold_off = 1'b0;
            end
         end
      end
      write_nodes(1024);
      drain();
      $display("Sent %0d transactions, checked %0d responses across gap phases,", sent, got);
      $display("node-count settings, bad vertex and index cases.");
      if (errors == 0 && expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #300ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/gbf_pkg.sv
hdl/gbf_ram.sv
hdl/graph_bridge_finder.sv
sim/graph_bridge_finder_tb.sv
